// ===== rtl/tvt_pkg.sv =====
// Package for the trace vertex target unit: field widths, angle modes, shared types.
package tvt_pkg;

  // Width of every coordinate field on the ports
  localparam int FIELD_W = 32;
  // Default number of coordinate bits in use
  localparam int COORD_BITS_DEF = 32;

  // Routing angle modes; the spare code behaves as any angle
  typedef enum logic [1:0] {
    MODE_ORTHO   = 2'd0,
    MODE_45      = 2'd1,
    MODE_ANY     = 2'd2,
    MODE_ANY_ALT = 2'd3
  } mode_t;

  // Control that rides along with a request through the divider
  typedef struct packed {
    logic use_div;
    logic dx_neg;
    logic dy_neg;
  } div_ctl_t;

endpackage

// ===== rtl/tvt_in_if.sv =====
// Vertex request channel: three vertices per request.
interface tvt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tvt_pkg::FIELD_W-1:0] prev_x;
  logic signed [tvt_pkg::FIELD_W-1:0] prev_y;
  logic signed [tvt_pkg::FIELD_W-1:0] cur_x;
  logic signed [tvt_pkg::FIELD_W-1:0] cur_y;
  logic signed [tvt_pkg::FIELD_W-1:0] next_x;
  logic signed [tvt_pkg::FIELD_W-1:0] next_y;
  modport source (output valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, input ready);
  modport sink (input valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, output ready);
endinterface

// ===== rtl/tvt_out_if.sv =====
// Target result channel: one proposed vertex position per request.
interface tvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tvt_pkg::FIELD_W-1:0] target_x;
  logic signed [tvt_pkg::FIELD_W-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

// ===== rtl/tvt_cfg_if.sv =====
// Configuration write channel for the angle mode register.
interface tvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] angle_mode;
  modport source (output valid, angle_mode, input ready);
  modport sink (input valid, angle_mode, output ready);
endinterface

// ===== rtl/tvt_prep.sv =====
// Front stages: differences, products, and sums of squares and dot product.
module tvt_prep #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  input  logic signed [W-1:0]   px_i,
  input  logic signed [W-1:0]   py_i,
  input  logic signed [W-1:0]   cx_i,
  input  logic signed [W-1:0]   cy_i,
  input  logic signed [W-1:0]   nx_i,
  input  logic signed [W-1:0]   ny_i,
  output logic                  v3,
  output logic [1:0]            mode3,
  output logic signed [W-1:0]   px3,
  output logic signed [W-1:0]   py3,
  output logic signed [W-1:0]   cx3,
  output logic signed [W-1:0]   cy3,
  output logic signed [W-1:0]   nx3,
  output logic signed [W-1:0]   ny3,
  output logic [2*W+1:0]        len2,
  output logic signed [2*W+2:0] nproj,
  output logic [2*W+1:0]        d1,
  output logic [2*W+1:0]        d2,
  output logic signed [W-1:0]   r45x,
  output logic signed [W-1:0]   r45y,
  output logic                  dxn,
  output logic                  dyn,
  output logic [W:0]            ax3,
  output logic [W:0]            ay3
);
  localparam int D = W + 1;
  localparam int L = 2 * D;

  logic                  v1, v2;
  logic [1:0]            mode1, mode2;
  logic signed [W-1:0]   px1, py1, cx1, cy1, nx1, ny1;
  logic signed [W-1:0]   px2, py2, cx2, cy2, nx2, ny2;
  logic signed [D-1:0]   dx1, dy1, ex1, ey1, ox1, oy1, qx1, qy1;
  logic signed [L-1:0]   sq_dx, sq_dy, pnx, pny, o1, o2, o3, o4;
  logic signed [W-1:0]   r45x2, r45y2;
  logic                  dxn2, dyn2;
  logic [D-1:0]          ax2, ay2;

  logic [D-1:0]          ax, ay, mag;
  logic                  big_x, big_y, pos_x, pos_y;
  logic [W+1:0]          stepx, stepy, sumx, sumy;
  logic [D-1:0]          sx, sy, sax, say;
  logic signed [W-1:0]   r45x_c, r45y_c;

  // Stage 1: register vertices and take differences
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      mode1 <= in_mode;
      px1 <= px_i; py1 <= py_i; cx1 <= cx_i; cy1 <= cy_i; nx1 <= nx_i; ny1 <= ny_i;
      dx1 <= {nx_i[W-1], nx_i} - {px_i[W-1], px_i};
      dy1 <= {ny_i[W-1], ny_i} - {py_i[W-1], py_i};
      ex1 <= {cx_i[W-1], cx_i} - {px_i[W-1], px_i};
      ey1 <= {cy_i[W-1], cy_i} - {py_i[W-1], py_i};
      ox1 <= {px_i[W-1], px_i} - {cx_i[W-1], cx_i};
      oy1 <= {ny_i[W-1], ny_i} - {cy_i[W-1], cy_i};
      qx1 <= {nx_i[W-1], nx_i} - {cx_i[W-1], cx_i};
      qy1 <= {py_i[W-1], py_i} - {cy_i[W-1], cy_i};
    end
  end

  // Forty-five degree target from the differences
  always_comb begin
    ax    = dx1[D-1] ? D'(-dx1) : D'(dx1);
    ay    = dy1[D-1] ? D'(-dy1) : D'(dy1);
    big_x = {1'b0, ax} > {ay, 1'b0};
    big_y = {1'b0, ay} > {ax, 1'b0};
    pos_x = !dx1[D-1] && (dx1 != '0);
    pos_y = !dy1[D-1] && (dy1 != '0);
    mag   = big_x ? ay : ax;
    stepx = pos_x ? {1'b0, mag} : -{1'b0, mag};
    stepy = pos_y ? {1'b0, mag} : -{1'b0, mag};
    sumx  = {{2{px1[W-1]}}, px1} + stepx;
    sumy  = {{2{py1[W-1]}}, py1} + stepy;
    sx    = {px1[W-1], px1} + {nx1[W-1], nx1};
    sy    = {py1[W-1], py1} + {ny1[W-1], ny1};
    sax   = sx + D'(sx[D-1]);
    say   = sy + D'(sy[D-1]);
    if (big_x || big_y) begin
      r45x_c = sumx[W-1:0];
      r45y_c = sumy[W-1:0];
    end else begin
      r45x_c = sax[D-1:1];
      r45y_c = say[D-1:1];
    end
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      mode2 <= mode1;
      px2 <= px1; py2 <= py1; cx2 <= cx1; cy2 <= cy1; nx2 <= nx1; ny2 <= ny1;
      sq_dx <= dx1 * dx1;
      sq_dy <= dy1 * dy1;
      pnx   <= ex1 * dx1;
      pny   <= ey1 * dy1;
      o1    <= ox1 * ox1;
      o2    <= oy1 * oy1;
      o3    <= qx1 * qx1;
      o4    <= qy1 * qy1;
      r45x2 <= r45x_c;
      r45y2 <= r45y_c;
      dxn2  <= dx1[D-1];
      dyn2  <= dy1[D-1];
      ax2   <= ax;
      ay2   <= ay;
    end
  end

  // Stage 3: sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      mode3 <= mode2;
      px3 <= px2; py3 <= py2; cx3 <= cx2; cy3 <= cy2; nx3 <= nx2; ny3 <= ny2;
      len2  <= sq_dx + sq_dy;
      nproj <= {pnx[L-1], pnx} + {pny[L-1], pny};
      d1    <= o1 + o2;
      d2    <= o3 + o4;
      r45x  <= r45x2;
      r45y  <= r45y2;
      dxn   <= dxn2;
      dyn   <= dyn2;
      ax3   <= ax2;
      ay3   <= ay2;
    end
  end

endmodule

// ===== rtl/tvt_classify.sv =====
// Mode selection, projection bounds and numerator partial products.
module tvt_classify #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v3,
  input  logic [1:0]            mode3,
  input  logic signed [W-1:0]   px3,
  input  logic signed [W-1:0]   py3,
  input  logic signed [W-1:0]   cx3,
  input  logic signed [W-1:0]   cy3,
  input  logic signed [W-1:0]   nx3,
  input  logic signed [W-1:0]   ny3,
  input  logic [2*W+1:0]        len2,
  input  logic signed [2*W+2:0] nproj,
  input  logic [2*W+1:0]        d1,
  input  logic [2*W+1:0]        d2,
  input  logic signed [W-1:0]   r45x,
  input  logic signed [W-1:0]   r45y,
  input  logic                  dxn,
  input  logic                  dyn,
  input  logic [W:0]            ax3,
  input  logic [W:0]            ay3,
  output logic                  v5,
  output tvt_pkg::div_ctl_t     ctl5,
  output logic signed [W-1:0]   rx5,
  output logic signed [W-1:0]   ry5,
  output logic signed [W-1:0]   px5,
  output logic signed [W-1:0]   py5,
  output logic [2*W+1:0]        len2_5,
  output logic [2*W+1:0]        remx,
  output logic [W:0]            lowx,
  output logic [2*W+1:0]        remy,
  output logic [W:0]            lowy
);
  import tvt_pkg::*;

  localparam int D = W + 1;
  localparam int L = 2 * D;

  logic                v4;
  div_ctl_t            ctl4, ctl_c;
  logic signed [W-1:0] rx4, ry4, px4, py4, rx_c, ry_c;
  logic [L-1:0]        len2_4, pxl, pxh, pyl, pyh;
  logic [3*D-1:0]      numx, numy;

  // Pick the target by mode; flag requests that need the divider
  always_comb begin
    ctl_c.dx_neg  = dxn;
    ctl_c.dy_neg  = dyn;
    ctl_c.use_div = 1'b0;
    rx_c = px3;
    ry_c = py3;
    unique case (mode3)
      MODE_ORTHO: begin
        if (py3 == ny3) begin
          rx_c = cx3; ry_c = py3;
        end else if (px3 == nx3) begin
          rx_c = px3; ry_c = cy3;
        end else if (d1 < d2) begin
          rx_c = px3; ry_c = ny3;
        end else begin
          rx_c = nx3; ry_c = py3;
        end
      end
      MODE_45: begin
        rx_c = r45x; ry_c = r45y;
      end
      default: begin
        if (len2 == '0) begin
          rx_c = cx3; ry_c = cy3;
        end else if (nproj[L] || (nproj == '0)) begin
          rx_c = px3; ry_c = py3;
        end else if (nproj[L-1:0] >= len2) begin
          rx_c = nx3; ry_c = ny3;
        end else begin
          ctl_c.use_div = 1'b1;
        end
      end
    endcase
  end

  // Stage 4: decision and split products of the numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ctl4   <= ctl_c;
      rx4    <= rx_c;
      ry4    <= ry_c;
      px4    <= px3;
      py4    <= py3;
      len2_4 <= len2;
      pxl    <= nproj[D-1:0] * ax3;
      pxh    <= nproj[L-1:D] * ax3;
      pyl    <= nproj[D-1:0] * ay3;
      pyh    <= nproj[L-1:D] * ay3;
    end
  end

  assign numx = {pxh, {D{1'b0}}} + {{D{1'b0}}, pxl};
  assign numy = {pyh, {D{1'b0}}} + {{D{1'b0}}, pyl};

  // Stage 5: assemble numerators and seed the division
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ctl5   <= ctl4;
      rx5    <= rx4;
      ry5    <= ry4;
      px5    <= px4;
      py5    <= py4;
      len2_5 <= len2_4;
      remx   <= numx[3*D-1:D];
      lowx   <= numx[D-1:0];
      remy   <= numy[3*D-1:D];
      lowy   <= numy[D-1:0];
    end
  end

endmodule

// ===== rtl/tvt_div_step.sv =====
// One restoring division step for both axes; one quotient bit per stage.
module tvt_div_step #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                v_i,
  input  tvt_pkg::div_ctl_t   ctl_i,
  input  logic signed [W-1:0] rx_i,
  input  logic signed [W-1:0] ry_i,
  input  logic signed [W-1:0] px_i,
  input  logic signed [W-1:0] py_i,
  input  logic [2*W+1:0]      len2_i,
  input  logic [2*W+1:0]      remx_i,
  input  logic [W:0]          lowx_i,
  input  logic [W:0]          qx_i,
  input  logic [2*W+1:0]      remy_i,
  input  logic [W:0]          lowy_i,
  input  logic [W:0]          qy_i,
  output logic                v_o,
  output tvt_pkg::div_ctl_t   ctl_o,
  output logic signed [W-1:0] rx_o,
  output logic signed [W-1:0] ry_o,
  output logic signed [W-1:0] px_o,
  output logic signed [W-1:0] py_o,
  output logic [2*W+1:0]      len2_o,
  output logic [2*W+1:0]      remx_o,
  output logic [W:0]          lowx_o,
  output logic [W:0]          qx_o,
  output logic [2*W+1:0]      remy_o,
  output logic [W:0]          lowy_o,
  output logic [W:0]          qy_o
);
  localparam int D = W + 1;
  localparam int L = 2 * D;

  logic [L:0]   tx, ty, tx_sub, ty_sub;
  logic         gex, gey;

  // Shift in the next numerator bit and try subtracting the divisor
  always_comb begin
    tx     = {remx_i, lowx_i[D-1]};
    ty     = {remy_i, lowy_i[D-1]};
    gex    = tx >= {1'b0, len2_i};
    gey    = ty >= {1'b0, len2_i};
    tx_sub = gex ? tx - {1'b0, len2_i} : tx;
    ty_sub = gey ? ty - {1'b0, len2_i} : ty;
  end

  // Advance one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
    if (en) begin
      ctl_o  <= ctl_i;
      rx_o   <= rx_i;
      ry_o   <= ry_i;
      px_o   <= px_i;
      py_o   <= py_i;
      len2_o <= len2_i;
      remx_o <= tx_sub[L-1:0];
      remy_o <= ty_sub[L-1:0];
      lowx_o <= {lowx_i[D-2:0], 1'b0};
      lowy_o <= {lowy_i[D-2:0], 1'b0};
      qx_o   <= {qx_i[D-2:0], gex};
      qy_o   <= {qy_i[D-2:0], gey};
    end
  end

endmodule

// ===== rtl/tvt_finish.sv =====
// Final stage: apply the projection quotient and hold the result register.
module tvt_finish #(
  parameter int W = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              v_i,
  input  tvt_pkg::div_ctl_t                 ctl_i,
  input  logic signed [W-1:0]               rx_i,
  input  logic signed [W-1:0]               ry_i,
  input  logic signed [W-1:0]               px_i,
  input  logic signed [W-1:0]               py_i,
  input  logic [2*W+1:0]                    remx_i,
  input  logic [W:0]                        qx_i,
  input  logic [2*W+1:0]                    remy_i,
  input  logic [W:0]                        qy_i,
  output logic                              out_valid,
  output logic signed [tvt_pkg::FIELD_W-1:0] target_x,
  output logic signed [tvt_pkg::FIELD_W-1:0] target_y
);
  import tvt_pkg::*;

  localparam int D = W + 1;

  logic signed [W-1:0] ax_c, ay_c, sel_x, sel_y;

  // Step from the previous vertex by the quotient, rounding toward zero
  function automatic logic signed [W-1:0] step_axis(input logic signed [W-1:0] p,
                                                    input logic neg,
                                                    input logic [D-1:0] q,
                                                    input logic inexact);
    logic [W+1:0] v;
    v = neg ? {{2{p[W-1]}}, p} - {1'b0, q} : {{2{p[W-1]}}, p} + {1'b0, q};
    if (inexact && !neg && v[W+1]) begin
      v = v + 1'b1;
    end else if (inexact && neg && !v[W+1] && (v != '0)) begin
      v = v - 1'b1;
    end
    return v[W-1:0];
  endfunction

  always_comb begin
    ax_c  = step_axis(px_i, ctl_i.dx_neg, qx_i, remx_i != '0);
    ay_c  = step_axis(py_i, ctl_i.dy_neg, qy_i, remy_i != '0);
    sel_x = ctl_i.use_div ? ax_c : rx_i;
    sel_y = ctl_i.use_div ? ay_c : ry_i;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_i;
    end
    if (en) begin
      target_x <= FIELD_W'(sel_x);
      target_y <= FIELD_W'(sel_y);
    end
  end

endmodule

// ===== rtl/trace_vertex_target_unit.sv =====
// Trace vertex target unit: pipelined tightening target for a polyline vertex.
//
// Requests arrive on vtx (prev, cur, next vertex); one result per request
// leaves on tgt as (target_x, target_y), in request order. The angle mode
// register is written over cfg (always ready) and is read when a request
// enters; write it only while the pipeline is empty.
// Only the low COORD_BITS bits of each coordinate are used, sign-extended.
// The pipeline has three front stages for differences, products and sums,
// two for mode selection and numerator products, one stage per quotient bit
// of the projection divider, and the output register. Throughput is one
// request per cycle while tgt is not stalled.
// The whole pipeline advances together: when tgt holds a result that is not
// taken, every stage holds and vtx.ready drops; bubbles move forward
// whenever the output register is empty or being read.
// Reset clears all stage valid bits and sets the angle mode to any angle.
module trace_vertex_target_unit #(
  parameter int COORD_BITS = tvt_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tvt_cfg_if.sink   cfg,
  tvt_in_if.sink    vtx,
  tvt_out_if.source tgt
);
  import tvt_pkg::*;

  localparam int W = COORD_BITS;
  localparam int D = W + 1;
  localparam int L = 2 * D;

  logic                en;
  logic [1:0]          angle_mode;

  logic                v3, dxn, dyn;
  logic [1:0]          mode3;
  logic signed [W-1:0] px3, py3, cx3, cy3, nx3, ny3, r45x, r45y;
  logic [L-1:0]        len2, d1, d2;
  logic signed [L:0]   nproj;
  logic [D-1:0]        ax3, ay3;

  logic                cv    [0:D];
  div_ctl_t            cc    [0:D];
  logic signed [W-1:0] crx   [0:D];
  logic signed [W-1:0] cry   [0:D];
  logic signed [W-1:0] cpx   [0:D];
  logic signed [W-1:0] cpy   [0:D];
  logic [L-1:0]        clen  [0:D];
  logic [L-1:0]        cremx [0:D];
  logic [L-1:0]        cremy [0:D];
  logic [D-1:0]        clowx [0:D];
  logic [D-1:0]        clowy [0:D];
  logic [D-1:0]        cqx   [0:D];
  logic [D-1:0]        cqy   [0:D];

  // Advance when the output register is free or being drained
  assign en        = !tgt.valid || tgt.ready;
  assign vtx.ready = en;
  assign cfg.ready = 1'b1;

  // Angle mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_mode <= MODE_ANY;
    end else if (cfg.valid) begin
      angle_mode <= cfg.angle_mode;
    end
  end

  tvt_prep #(.W(W)) u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(vtx.valid), .in_mode(angle_mode),
    .px_i(vtx.prev_x[W-1:0]), .py_i(vtx.prev_y[W-1:0]),
    .cx_i(vtx.cur_x[W-1:0]), .cy_i(vtx.cur_y[W-1:0]),
    .nx_i(vtx.next_x[W-1:0]), .ny_i(vtx.next_y[W-1:0]),
    .v3(v3), .mode3(mode3), .px3(px3), .py3(py3), .cx3(cx3), .cy3(cy3),
    .nx3(nx3), .ny3(ny3), .len2(len2), .nproj(nproj), .d1(d1), .d2(d2),
    .r45x(r45x), .r45y(r45y), .dxn(dxn), .dyn(dyn), .ax3(ax3), .ay3(ay3)
  );

  tvt_classify #(.W(W)) u_classify (
    .clk(clk), .rst(rst), .en(en), .v3(v3), .mode3(mode3),
    .px3(px3), .py3(py3), .cx3(cx3), .cy3(cy3), .nx3(nx3), .ny3(ny3),
    .len2(len2), .nproj(nproj), .d1(d1), .d2(d2), .r45x(r45x), .r45y(r45y),
    .dxn(dxn), .dyn(dyn), .ax3(ax3), .ay3(ay3),
    .v5(cv[0]), .ctl5(cc[0]), .rx5(crx[0]), .ry5(cry[0]), .px5(cpx[0]), .py5(cpy[0]),
    .len2_5(clen[0]), .remx(cremx[0]), .lowx(clowx[0]), .remy(cremy[0]),
    .lowy(clowy[0])
  );

  assign cqx[0] = '0;
  assign cqy[0] = '0;

  // Projection divider: one quotient bit per stage
  for (genvar k = 0; k < D; k++) begin : g_div
    tvt_div_step #(.W(W)) u_step (
      .clk(clk), .rst(rst), .en(en), .v_i(cv[k]), .ctl_i(cc[k]),
      .rx_i(crx[k]), .ry_i(cry[k]), .px_i(cpx[k]), .py_i(cpy[k]), .len2_i(clen[k]),
      .remx_i(cremx[k]), .lowx_i(clowx[k]), .qx_i(cqx[k]),
      .remy_i(cremy[k]), .lowy_i(clowy[k]), .qy_i(cqy[k]),
      .v_o(cv[k+1]), .ctl_o(cc[k+1]), .rx_o(crx[k+1]), .ry_o(cry[k+1]),
      .px_o(cpx[k+1]), .py_o(cpy[k+1]), .len2_o(clen[k+1]),
      .remx_o(cremx[k+1]), .lowx_o(clowx[k+1]), .qx_o(cqx[k+1]),
      .remy_o(cremy[k+1]), .lowy_o(clowy[k+1]), .qy_o(cqy[k+1])
    );
  end

  tvt_finish #(.W(W)) u_finish (
    .clk(clk), .rst(rst), .en(en), .v_i(cv[D]), .ctl_i(cc[D]),
    .rx_i(crx[D]), .ry_i(cry[D]), .px_i(cpx[D]), .py_i(cpy[D]),
    .remx_i(cremx[D]), .qx_i(cqx[D]), .remy_i(cremy[D]), .qy_i(cqy[D]),
    .out_valid(tgt.valid), .target_x(tgt.target_x), .target_y(tgt.target_y)
  );

  // Reset leaves the mode at any angle
  a_reset_mode: assert property (@(posedge clk) rst |=> angle_mode == MODE_ANY)
    else $error("angle mode not at reset value");

  // Input stalls only behind an undrained result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !vtx.ready |-> tgt.valid && !tgt.ready)
    else $error("input stalled without output backpressure");

  // A stall freezes the divider entry stage
  a_hold_div: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cv[0]) && $stable(cremx[0]))
    else $error("pipeline moved during stall");

  // Requests that skip the divider keep their selected result
  a_div_flag: assert property (@(posedge clk) disable iff (rst)
    en && cv[D-1] && !cc[D-1].use_div |=> crx[D] == $past(crx[D-1]))
    else $error("bypass result changed in divider");

endmodule
